// ===== src/hfba_pkg.sv =====
// Shared types, codes and control structs of the huge-frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package hfba_pkg;

	// Fixed field widths.
	localparam int ADDR_W    = 36;
	localparam int END_W     = 37;
	localparam int STATUS_W  = 3;
	localparam int FREED_W   = 16;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 36;

	// Addresses below 1 GiB are always treated as kernel frames.
	localparam logic [END_W-1:0] KERNEL_FLOOR = 37'h0_4000_0000;

	// Operation modes.
	localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RANGE   = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_KERNEL_SKIP = 3'd3;
	localparam logic [STATUS_W-1:0] ST_KERNEL_VIOL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_IN_USE  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_DONE   = 2'd2;

	// Input word.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] address;
		logic [END_W-1:0]  range_end;
	} item_t;

	// Result word.
	typedef struct packed {
		logic [ADDR_W-1:0]   frame_address;
		logic [STATUS_W-1:0] status;
		logic                in_use;
		logic [FREED_W-1:0]  freed_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                clr_step;
		logic                scan_rd;
		logic                scan_take;
		logic                rd_frame;
		logic                next_frame;
		logic                clear_bit;
		logic                take_bit;
		logic                set_err;
		logic [STATUS_W-1:0] err_code;
	} hfba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic                clr_last;
		logic                count_zero;
		logic                scan_found;
		logic                walk_end;
		logic                chk_fail;
		logic                chk_skip;
		logic [STATUS_W-1:0] chk_code;
		logic                bit_set;
	} hfba_stat_t;

endpackage
`default_nettype wire

// ===== src/huge_frame_bitmap_allocator_unit.sv =====
// Top level of the huge-frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator for 2^FRAME_SHIFT-byte physical frames over a used-bit map of
// MAP_WORDS 64-bit words held in one RAM. A word is taken when start is high and busy
// is low; its single result appears for exactly one cycle with done high and cannot be
// held off. After reset the block sweeps the map to all ones, one word per cycle, and
// stays busy until the sweep is done, before the first word is taken. A request
// reads map words in order up to the first word with a free frame (none when
// nothing is free); a free checks the address, then reads and clears its bit (no
// read on an error found by the address checks); a query reads its bit (no read
// beyond the map); a range free reads and clears the bit of each frame freed, steps
// over kernel frames skipped, and stops at the range end or on a frame not in use.
// Configuration writes take effect at once and belong to idle periods.
module huge_frame_bitmap_allocator_unit #(
	parameter int MAP_WORDS   = 512,
	parameter int FRAME_SHIFT = 21
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire hfba_pkg::item_t                item,
	output logic                                done,
	output hfba_pkg::result_t                   result,
	input  wire logic                           cfg_we,
	input  wire logic [hfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hfba_pkg::CFG_W-1:0]     cfg_wdata
);
	import hfba_pkg::*;

	hfba_cmd_t  cmd;
	hfba_stat_t stat;

	hfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	hfba_datapath #(
		.MAP_WORDS   (MAP_WORDS),
		.FRAME_SHIFT (FRAME_SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	// A result only ever ends an operation in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside an operation");

	// An accepted word makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not start an operation");

	// A granted frame address comes only with an ok status.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.frame_address != '0)) |-> (result.status == ST_OK))
		else $error("frame address reported with an error status");

	// Status stays within the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status != 3'd7))
		else $error("undefined status code");

endmodule
`default_nettype wire

// ===== src/hfba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hfba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/hfba_datapath.sv =====
// Datapath of the allocator: used-bit map, counters, frame walk and result word.
`timescale 1ns / 1ps
`default_nettype none
module hfba_datapath #(
	parameter int MAP_WORDS   = 512,
	parameter int FRAME_SHIFT = 21
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire hfba_pkg::item_t             item,
	input  wire logic                        cfg_we,
	input  wire logic [hfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hfba_pkg::CFG_W-1:0]  cfg_wdata,
	input  wire hfba_pkg::hfba_cmd_t         cmd,
	output hfba_pkg::hfba_stat_t             stat,
	output hfba_pkg::result_t                result
);
	import hfba_pkg::*;

	localparam int WORD_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int FRAMES  = MAP_WORDS * 64;
	localparam int CNT_W   = $clog2(FRAMES + 1);
	localparam int IDX_W   = END_W - FRAME_SHIFT;
	localparam logic [END_W:0] FRAME_SIZE = (END_W + 1)'(1) << FRAME_SHIFT;
	localparam logic [END_W:0] FRAME_MASK = FRAME_SIZE - (END_W + 1)'(1);

	// Configuration registers.
	logic [ADDR_W-1:0] kern_lo_q;
	logic [ADDR_W-1:0] kern_hi_q;
	logic              init_done_q;

	// Control state.
	logic [WORD_AW-1:0] clr_ptr_q;
	logic [WORD_AW:0]   scan_ptr_q;
	logic               scan_vld_q;
	logic [WORD_AW-1:0] scan_tag_q;
	logic [CNT_W-1:0]   free_cnt_q;

	// Operation registers.
	logic [MODE_W-1:0] mode_q;
	logic [END_W-1:0]  p_q;
	logic [END_W-1:0]  end_q;
	logic              short_q;
	result_t           res_q;

	// Map memory signals.
	logic               ram_we;
	logic [WORD_AW-1:0] ram_waddr;
	logic [63:0]        ram_wdata;
	logic               ram_re;
	logic [WORD_AW-1:0] ram_raddr;
	logic [63:0]        ram_rdata;

	// Derived values.
	logic [IDX_W-1:0]   idx;
	logic [31:0]        idx_ext;
	logic [WORD_AW-1:0] word_addr;
	logic [5:0]         bit_sel;
	logic               out_of_map;
	logic               misaligned;
	logic               kernel;
	logic               more;
	logic               scan_go;
	logic [5:0]         first_zero;
	logic [63:0]        zero_mask;
	logic [63:0]        bit_mask;
	logic [WORD_AW+5:0] found_idx;
	logic [63:0]        found_frame;
	logic [END_W:0]     addr_ext;
	logic [END_W:0]     addr_plus;
	logic [END_W:0]     addr_round;

	// Index of the lowest clear bit of a word.
	function automatic logic [5:0] lowest_zero(input logic [63:0] w);
		logic [5:0] b;
		b = '0;
		for (int i = 63; i >= 0; i--) begin
			if (!w[i]) begin
				b = 6'(i);
			end
		end
		return b;
	endfunction

	hfba_ram #(
		.WIDTH (64),
		.DEPTH (MAP_WORDS),
		.AW    (WORD_AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Frame index, word and bit of the current walk address.
	assign idx        = p_q[END_W-1:FRAME_SHIFT];
	assign idx_ext    = 32'(idx);
	assign word_addr  = idx_ext[WORD_AW+5:6];
	assign bit_sel    = idx[5:0];
	assign out_of_map = idx_ext >= 32'(FRAMES);
	assign misaligned = |(p_q & FRAME_MASK[END_W-1:0]);
	assign kernel     = ((p_q >= {1'b0, kern_lo_q}) && (p_q <= {1'b0, kern_hi_q}))
		|| (p_q < KERNEL_FLOOR);
	assign more       = ({1'b0, p_q} + FRAME_SIZE) <= {1'b0, end_q};
	assign bit_mask   = 64'(1) << bit_sel;

	// Range start rounded up to a frame boundary, and the short-range test.
	assign addr_ext   = (END_W + 1)'(item.address);
	assign addr_plus  = addr_ext + FRAME_SIZE;
	assign addr_round = (addr_ext + FRAME_MASK) & ~FRAME_MASK;

	// Scan: the word in the read register holds a clear bit.
	assign scan_go     = cmd.scan_rd && (scan_ptr_q < (WORD_AW + 1)'(MAP_WORDS));
	assign first_zero  = lowest_zero(ram_rdata);
	assign zero_mask   = 64'(1) << first_zero;
	assign found_idx   = {scan_tag_q, first_zero};
	assign found_frame = 64'(found_idx) << FRAME_SHIFT;

	// Memory port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_ptr_q;
		ram_wdata = '1;
		if (cmd.clr_step) begin
			ram_we = 1'b1;
		end else if (cmd.scan_take) begin
			ram_we    = 1'b1;
			ram_waddr = scan_tag_q;
			ram_wdata = ram_rdata | zero_mask;
		end else if (cmd.clear_bit) begin
			ram_we    = 1'b1;
			ram_waddr = word_addr;
			ram_wdata = ram_rdata & ~bit_mask;
		end
		ram_re    = scan_go || cmd.rd_frame;
		ram_raddr = cmd.rd_frame ? word_addr : scan_ptr_q[WORD_AW-1:0];
	end

	// Frame checks for free, query and range walk.
	always_comb begin
		stat.chk_fail = 1'b0;
		stat.chk_skip = 1'b0;
		stat.chk_code = ST_OK;
		case (mode_q)
			MODE_QUERY: begin
				if (out_of_map) begin
					stat.chk_fail = 1'b1;
					stat.chk_code = ST_RANGE;
				end
			end
			MODE_FREE, MODE_RANGE: begin
				if (misaligned) begin
					stat.chk_fail = 1'b1;
					stat.chk_code = ST_MISALIGNED;
				end else if (kernel) begin
					if (init_done_q) begin
						stat.chk_fail = 1'b1;
						stat.chk_code = ST_KERNEL_VIOL;
					end else if (mode_q == MODE_RANGE) begin
						stat.chk_skip = 1'b1;
					end else begin
						stat.chk_fail = 1'b1;
						stat.chk_code = ST_KERNEL_SKIP;
					end
				end else if (out_of_map) begin
					stat.chk_fail = 1'b1;
					stat.chk_code = ST_RANGE;
				end
			end
			default: begin
				stat.chk_fail = 1'b0;
			end
		endcase
		stat.mode       = mode_q;
		stat.clr_last   = clr_ptr_q == WORD_AW'(MAP_WORDS - 1);
		stat.count_zero = free_cnt_q == '0;
		stat.scan_found = scan_vld_q && (ram_rdata != '1);
		stat.walk_end   = (mode_q == MODE_RANGE) && (short_q || !more);
		stat.bit_set    = ram_rdata[bit_sel];
	end

	// Configuration and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_lo_q   <= '0;
			kern_hi_q   <= '0;
			init_done_q <= 1'b0;
			clr_ptr_q   <= '0;
			scan_ptr_q  <= '0;
			scan_vld_q  <= 1'b0;
			scan_tag_q  <= '0;
			free_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KERNEL_LOW:  kern_lo_q   <= cfg_wdata;
					CFG_KERNEL_HIGH: kern_hi_q   <= cfg_wdata;
					CFG_INIT_DONE:   init_done_q <= cfg_wdata[0];
					default:         init_done_q <= init_done_q;
				endcase
			end
			if (cmd.clr_step) begin
				clr_ptr_q <= clr_ptr_q + WORD_AW'(1);
			end
			if (cmd.load) begin
				scan_ptr_q <= '0;
				scan_vld_q <= 1'b0;
			end else if (cmd.scan_rd) begin
				scan_vld_q <= scan_go;
				if (scan_go) begin
					scan_ptr_q <= scan_ptr_q + (WORD_AW + 1)'(1);
					scan_tag_q <= scan_ptr_q[WORD_AW-1:0];
				end
			end
			if (cmd.scan_take) begin
				free_cnt_q <= free_cnt_q - CNT_W'(1);
			end else if (cmd.clear_bit) begin
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end
		end
	end

	// Operation registers and result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= item.mode;
			end_q   <= item.range_end;
			short_q <= {1'b0, item.range_end} < addr_plus;
			p_q     <= (item.mode == MODE_RANGE) ? addr_round[END_W-1:0]
				: END_W'(item.address);
			res_q.frame_address <= '0;
			res_q.status        <= (item.mode == MODE_REQUEST) ? ST_NO_FREE : ST_OK;
			res_q.in_use        <= 1'b0;
			res_q.freed_count   <= '0;
		end else begin
			if (cmd.next_frame) begin
				p_q <= p_q + FRAME_SIZE[END_W-1:0];
			end
			if (cmd.scan_take) begin
				res_q.frame_address <= found_frame[ADDR_W-1:0];
				res_q.status        <= ST_OK;
			end
			if (cmd.set_err) begin
				res_q.status <= cmd.err_code;
			end
			if (cmd.take_bit) begin
				res_q.in_use <= ram_rdata[bit_sel];
			end
			// Only a range walk reports how many frames it freed.
			if (cmd.clear_bit && (mode_q == MODE_RANGE)) begin
				res_q.freed_count <= res_q.freed_count + FREED_W'(1);
			end
		end
	end

	assign result = res_q;

endmodule
`default_nettype wire

// ===== src/hfba_ctrl.sv =====
// Controller state machine of the allocator.
`timescale 1ns / 1ps
`default_nettype none
module hfba_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire hfba_pkg::hfba_stat_t stat,
	output hfba_pkg::hfba_cmd_t       cmd,
	output logic                      busy,
	output logic                      done
);
	import hfba_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_CHECK,
		S_BITTEST,
		S_QBIT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				if (stat.mode != MODE_REQUEST) begin
					state_d = S_CHECK;
				end else if (stat.count_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_found) begin
					cmd.scan_take = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_CHECK: begin
				if (stat.walk_end) begin
					state_d = S_DONE;
				end else if (stat.chk_fail) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = stat.chk_code;
					state_d      = S_DONE;
				end else if (stat.chk_skip) begin
					cmd.next_frame = 1'b1;
				end else begin
					cmd.rd_frame = 1'b1;
					state_d      = (stat.mode == MODE_QUERY) ? S_QBIT : S_BITTEST;
				end
			end
			S_BITTEST: begin
				if (!stat.bit_set) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_NOT_IN_USE;
					state_d      = S_DONE;
				end else begin
					cmd.clear_bit = 1'b1;
					if (stat.mode == MODE_RANGE) begin
						cmd.next_frame = 1'b1;
						state_d        = S_CHECK;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_QBIT: begin
				cmd.take_bit = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; the map is swept to all ones after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule
`default_nettype wire
